### hw/rtl/tar_pkg.sv
`timescale 1ns / 1ps
package tar_pkg;

  localparam int INNER_MAX = 1024;
  localparam int AXIS_MAX  = 4096;
  localparam int POS_W     = $clog2(INNER_MAX);
  localparam int ACC_W     = 48;
  localparam int DATA_W    = 32;
  localparam int ALEN_W    = 13;

  // mode codes
  localparam logic [2:0] MODE_SUM  = 3'd0;
  localparam logic [2:0] MODE_MEAN = 3'd1;
  localparam logic [2:0] MODE_MAX  = 3'd2;
  localparam logic [2:0] MODE_MIN  = 3'd3;
  localparam logic [2:0] MODE_PROD = 3'd4;
  localparam logic [2:0] MODE_SQ   = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_AXIS  = 2'd1;
  localparam logic [1:0] CFG_INNER = 2'd2;
  localparam logic [1:0] CFG_OUTER = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [ACC_W-1:0] data;
  } acc_wr_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [ALEN_W-1:0] divisor;
  } div_req_t;

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? ACC_LO : ACC_HI;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W:0] v);
    logic [DATA_W-1:0] r;
    if (v > 49'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -49'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/tensor_axis_reduce_top.sv
`timescale 1ns / 1ps
// channel  dir  ports                                                     handshake
// in       in   in_sample                                                 in_valid / in_stall
// out      out  out_reduced, out_position, out_slice_end, out_tensor_end  out_valid / out_stall
// cfg      in   cfg_index, cfg_data                                       cfg_valid / cfg_ready
//
// an element is accepted with an accumulator read, then takes two multiply passes on the
// shared 32x32 multiplier, then an update that writes back to the accumulator ram
// a result on the last axis row adds the result state; mean mode adds the wait on the
// bit-serial divider (one quotient bit per cycle over 48 bits)
// in_stall is high while an element is in flight; the output register lets the next
// element start while a result waits on out_stall
// rst_n is synchronous; config, counters and state clear, the accumulator ram is not cleared
module tensor_axis_reduce_top import tar_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_reduced,
  output logic [POS_W-1:0]         out_position,
  output logic                     out_slice_end,
  output logic                     out_tensor_end,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // configuration registers
  logic [2:0]        mode_r;
  logic [ALEN_W-1:0] axis_len_r;
  logic [10:0]       inner_len_r;
  logic [15:0]       outer_len_r;

  // stream position
  logic [11:0]      axis_count_r;
  logic [POS_W-1:0] inner_count_r;
  logic [15:0]      outer_count_r;

  logic [2:0] state_r, state_nxt;

  // per element context
  logic signed [DATA_W-1:0] x_r;
  logic [POS_W-1:0]         pos_r;
  logic                     first_r, last_row_r, last_inner_r, last_outer_r;
  logic [2:0]               mode_q_r;
  logic [ALEN_W-1:0]        ea_q_r;
  logic [63:0]              m1_r;
  logic [31:0]              m2_r;
  logic [ACC_W-1:0]         new_acc_r;
  logic [DATA_W-1:0]        res_r;

  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_reduced_r;
  logic [POS_W-1:0]         out_position_r;
  logic                     out_slice_end_r, out_tensor_end_r;

  logic cfg_wr, in_acc;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SUM;
      axis_len_r  <= ALEN_W'(1);
      inner_len_r <= 11'd1;
      outer_len_r <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MODE:  mode_r      <= cfg_data[2:0];
        CFG_AXIS:  axis_len_r  <= cfg_data[ALEN_W-1:0];
        CFG_INNER: inner_len_r <= cfg_data[10:0];
        CFG_OUTER: outer_len_r <= cfg_data;
        default:   mode_r      <= mode_r;
      endcase
    end
  end

  // effective lengths, zero counts as one; axis and inner lengths are clamped to their maxima
  logic [ALEN_W-1:0] ea;
  logic [10:0]       ei, ei_m1;
  logic [15:0]       eo;
  assign ea = (axis_len_r == '0) ? ALEN_W'(1) :
              (axis_len_r > ALEN_W'(AXIS_MAX)) ? ALEN_W'(AXIS_MAX) : axis_len_r;
  assign ei = (inner_len_r == '0) ? 11'd1 :
              (inner_len_r > 11'(INNER_MAX)) ? 11'(INNER_MAX) : inner_len_r;
  assign eo = (outer_len_r == '0) ? 16'd1 : outer_len_r;
  assign ei_m1 = ei - 11'd1;

  logic [10:0]       inner_p1;
  logic [ALEN_W-1:0] axis_p1;
  logic [16:0]       outer_p1;
  logic              last_inner, last_row, last_outer;
  logic [POS_W-1:0]  pos;
  assign inner_p1   = {1'b0, inner_count_r} + 11'd1;
  assign axis_p1    = {1'b0, axis_count_r} + ALEN_W'(1);
  assign outer_p1   = {1'b0, outer_count_r} + 17'd1;
  assign last_inner = inner_p1 >= ei;
  assign last_row   = axis_p1 >= ea;
  assign last_outer = outer_p1 >= {1'b0, eo};
  // a counter left beyond a shortened length sits on the last index
  assign pos = ({1'b0, inner_count_r} < ei) ? inner_count_r : ei_m1[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r  <= '0;
      inner_count_r <= '0;
      outer_count_r <= '0;
    end else if (in_acc) begin
      if (!last_inner) begin
        inner_count_r <= pos + POS_W'(1);
      end else begin
        inner_count_r <= '0;
        if (!last_row) begin
          axis_count_r <= axis_p1[11:0];
        end else begin
          axis_count_r  <= '0;
          outer_count_r <= last_outer ? 16'd0 : outer_p1[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r          <= in_sample;
      pos_r        <= pos;
      first_r      <= (axis_count_r == '0);
      last_row_r   <= last_row;
      last_inner_r <= last_inner;
      last_outer_r <= last_outer;
      mode_q_r     <= mode_r;
      ea_q_r       <= ea;
    end
  end

  // accumulator ram
  logic [ACC_W-1:0] rd_data;
  acc_wr_t          acc_wr;

  tar_acc_mem u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos),
    .rd_data (rd_data),
    .wr      (acc_wr)
  );

  // shared multiplier on magnitudes
  logic signed [ACC_W-1:0] acc;
  logic [DATA_W-1:0]       x_mag;
  logic [ACC_W-1:0]        acc_mag;
  logic [DATA_W-1:0]       mul_a;
  logic [63:0]             mul_p;
  assign acc     = rd_data;
  assign x_mag   = x_r[DATA_W-1] ? DATA_W'(-x_r) : DATA_W'(x_r);
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  always_comb begin
    if (state_r == ST_MUL2) begin
      mul_a = {16'd0, acc_mag[15:0]};
    end else if (mode_q_r == MODE_SQ) begin
      mul_a = x_mag;
    end else begin
      mul_a = acc_mag[47:16];
    end
  end
  assign mul_p = 64'(mul_a) * 64'(x_mag);

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL1) begin
      m1_r <= mul_p;
    end
    if (state_r == ST_MUL2) begin
      m2_r <= mul_p[47:16];
    end
  end

  // accumulator update
  logic signed [ACC_W-1:0] x_ext, sq, add_in, prod_val, new_acc;
  logic [64:0]             prod_sum;
  logic [ACC_W-1:0]        prod_mag;
  logic                    prod_neg;
  assign x_ext    = ACC_W'(x_r);
  assign sq       = m1_r[63:16];
  assign add_in   = (mode_q_r == MODE_SQ) ? sq : x_ext;
  assign prod_sum = {1'b0, m1_r} + {33'd0, m2_r};
  assign prod_mag = (prod_sum > 65'h8000_0000_0000) ? 48'h8000_0000_0000 : prod_sum[47:0];
  assign prod_neg = acc[ACC_W-1] != x_r[DATA_W-1];
  assign prod_val = prod_neg ? ACC_W'(-prod_mag) :
                    (prod_mag[ACC_W-1] ? ACC_HI : prod_mag);

  always_comb begin
    if (first_r) begin
      new_acc = add_in;
    end else begin
      case (mode_q_r)
        MODE_MAX:  new_acc = (x_ext > acc) ? x_ext : acc;
        MODE_MIN:  new_acc = (x_ext < acc) ? x_ext : acc;
        MODE_PROD: new_acc = prod_val;
        default:   new_acc = sat48({acc[ACC_W-1], acc} + {add_in[ACC_W-1], add_in});
      endcase
    end
  end

  assign acc_wr.en   = (state_r == ST_UPD);
  assign acc_wr.addr = pos_r;
  assign acc_wr.data = new_acc;

  // mean divider
  div_req_t          div_req;
  logic              div_done;
  logic [ACC_W-1:0]  div_q;
  logic signed [ACC_W:0] mean_val;
  assign div_req.start    = (state_r == ST_UPD) && last_row_r && (mode_q_r == MODE_MEAN);
  assign div_req.dividend = new_acc[ACC_W-1] ? ACC_W'(-new_acc) : ACC_W'(new_acc);
  assign div_req.divisor  = ea_q_r;

  tar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mean_val = new_acc_r[ACC_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      new_acc_r <= new_acc;
      res_r     <= sat32({new_acc[ACC_W-1], new_acc});
    end else if (state_r == ST_DIV && div_done) begin
      res_r <= sat32(mean_val);
    end
  end

  // sequencer
  logic out_free;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_UPD;
      ST_UPD: begin
        if (!last_row_r) begin
          state_nxt = ST_IDLE;
        end else if (mode_q_r == MODE_MEAN) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  logic out_load;
  assign out_load = (state_r == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reduced_r    <= res_r;
      out_position_r   <= pos_r;
      out_slice_end_r  <= last_inner_r;
      out_tensor_end_r <= last_inner_r & last_outer_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reduced    = out_reduced_r;
  assign out_position   = out_position_r;
  assign out_slice_end  = out_slice_end_r;
  assign out_tensor_end = out_tensor_end_r;

  // every accepted element is written back in the update state after the two multiply states
  a_wb_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 acc_wr.en)
    else $error("accumulator write back missing");

  // the divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider done outside wait state");

  // a new result is loaded only from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r) == ST_OUT)
    else $error("result loaded outside result state");

  // the divisor is never zero
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("zero divisor");

endmodule

### hw/rtl/tar_acc_mem.sv
`timescale 1ns / 1ps
module tar_acc_mem import tar_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [POS_W-1:0] rd_addr,
  output logic [ACC_W-1:0] rd_data,
  input  acc_wr_t          wr
);

  logic [ACC_W-1:0] mem [INNER_MAX];
  logic [ACC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/tar_div.sv
`timescale 1ns / 1ps
module tar_div import tar_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [ACC_W-1:0] quotient
);

  localparam int CNT_W = $clog2(ACC_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [ACC_W-1:0]  quo_r;
  logic [ALEN_W-1:0] rem_r;
  logic [ALEN_W-1:0] dvs_r;
  logic [ALEN_W:0]   rem_sh;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[ACC_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ACC_W-2:0], ge};
      rem_r <= ge ? ALEN_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[ALEN_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
